// File: design/rcfd_pkg.sv
// Shared types and constants for the receiver frame decoder.
package rcfd_pkg;

  localparam int FRAME_BYTES  = 18;
  localparam int NUM_KEYS     = 18;
  localparam int HOLD_BITS_DEF = 8;
  localparam int NUM_STICKS   = 5;
  localparam int STICK_W      = 11;
  localparam int STICK_OUT_W  = 12;
  localparam int WDOG_W       = 8;
  localparam int COUNT_W      = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(FRAME_BYTES - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WDOG      = 2'd3;

  localparam logic [STICK_W-1:0] STICK_MIN_RST = 11'd364;
  localparam logic [STICK_W-1:0] STICK_MAX_RST = 11'd1684;
  localparam logic [STICK_W-1:0] CENTER_RST    = 11'd1024;
  localparam logic [WDOG_W-1:0]  WDOG_RST      = 8'd50;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic CAUSE_FRAME    = 1'b0;
  localparam logic CAUSE_WATCHDOG = 1'b1;

  typedef struct packed {
    logic [STICK_W-1:0] stick_min;
    logic [STICK_W-1:0] stick_max;
    logic [STICK_W-1:0] center;
    logic [WDOG_W-1:0]  reload;
  } cfg_t;

  // Item held in the input stage, as seen by the decode stage.
  typedef struct packed {
    logic valid;
    logic tick;
    logic frame_done;
  } item_t;

endpackage

// File: design/rcfd_if.sv
// Stream interfaces for receiver items and decoded results.
interface rcfd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, op, rx_byte, frame_end, input ready);
  modport sink (input valid, op, rx_byte, frame_end, output ready);
endinterface

interface rcfd_out_if;
  logic        valid;
  logic        ready;
  logic        cause;
  logic        link_lost;
  logic [59:0] sticks_packed;
  logic [3:0]  switch_pair;
  logic [47:0] mouse_packed;
  logic [17:0] keys_pressed;
  logic [17:0] keys_rising;
  logic [17:0] keys_falling;
  logic [47:0] hold_low;
  logic [47:0] hold_mid;
  logic [47:0] hold_high;

  modport source (output valid, cause, link_lost, sticks_packed, switch_pair, mouse_packed,
                  keys_pressed, keys_rising, keys_falling, hold_low, hold_mid, hold_high,
                  input ready);
  modport sink (input valid, cause, link_lost, sticks_packed, switch_pair, mouse_packed,
                keys_pressed, keys_rising, keys_falling, hold_low, hold_mid, hold_high,
                output ready);
endinterface

// File: design/rcfd_collect.sv
// Input stage: holds the accepted beat, counts frame bytes and fills the frame buffer.
module rcfd_collect import rcfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  input  logic       take_i,
  output item_t      item_o,
  output logic [7:0] frame_o [FRAME_BYTES]
);

  logic               item_v_q;
  logic               op_q;
  logic [7:0]         byte_q;
  logic               end_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [7:0]         buf_q [FRAME_BYTES];
  logic               advance;
  logic               is_byte;

  assign advance    = item_v_q && take_i;
  assign in_ready_o = !item_v_q || take_i;
  assign is_byte    = (op_q == OP_BYTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
    end else if (in_ready_o) begin
      item_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= op_i;
      byte_q <= rx_byte_i;
      end_q  <= frame_end_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (count_q != COUNT_MAX) begin
      count_d = count_q + COUNT_W'(1);
    end
    if (end_q) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (advance && is_byte) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (advance && is_byte && (count_q == COUNT_W'(i))) begin
        buf_q[i] <= byte_q;
      end
    end
  end

  // The closing byte is not yet in the buffer, so it is merged in here.
  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_o[i] = (count_q == COUNT_W'(i)) ? byte_q : buf_q[i];
    end
  end

  assign item_o.valid      = item_v_q;
  assign item_o.tick       = (op_q == OP_TICK);
  assign item_o.frame_done = is_byte && end_q && (count_q == COUNT_LAST);

endmodule

// File: design/rcfd_decode.sv
// Decode stage: unpacks and checks a frame, tracks keys and the watchdog, holds the result.
module rcfd_decode import rcfd_pkg::*; #(
  parameter int HOLD_BITS = HOLD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  item_t      item_i,
  input  logic [7:0] frame_i [FRAME_BYTES],
  output logic       take_o,
  rcfd_out_if.source out_o
);

  logic [STICK_W-1:0]   ch [NUM_STICKS];
  logic [1:0]           sw0, sw1;
  logic                 frame_ok;
  logic [NUM_KEYS-1:0]  keys_now;
  logic [WDOG_W-1:0]    online_dec;
  logic                 expire;
  logic                 advance;
  logic                 do_frame, do_clear, do_keys;
  logic [NUM_KEYS-1:0]  key_in;

  logic                 out_v_q;
  logic                 cause_q;
  logic                 lost_q;
  logic [WDOG_W-1:0]    online_q;
  logic [59:0]          stick_q;
  logic [3:0]           sw_q;
  logic [47:0]          mouse_q;
  logic [NUM_KEYS-1:0]  pressed_q, rise_q, fall_q;
  logic [HOLD_BITS-1:0] hold_q [NUM_KEYS];
  logic [59:0]          stick_d;
  logic [7:0]           hold8 [NUM_KEYS];
  logic [HOLD_BITS+7:0] hold_ext;

  always_comb begin
    ch[0] = {frame_i[1][2:0], frame_i[0]};
    ch[1] = {frame_i[2][5:0], frame_i[1][7:3]};
    ch[2] = {frame_i[4][0], frame_i[3], frame_i[2][7:6]};
    ch[3] = {frame_i[5][3:0], frame_i[4][7:1]};
    ch[4] = {frame_i[17][2:0], frame_i[16]};
  end

  assign sw0 = frame_i[5][5:4];
  assign sw1 = frame_i[5][7:6];
  assign frame_ok = (ch[0] >= cfg_i.stick_min) && (ch[0] <= cfg_i.stick_max)
                 && (sw0 != 2'd0) && (sw1 != 2'd0);
  assign keys_now = {(frame_i[13] != 8'd0), (frame_i[12] != 8'd0),
                     frame_i[15], frame_i[14]};

  always_comb begin
    for (int i = 0; i < NUM_STICKS; i++) begin
      stick_d[i*STICK_OUT_W +: STICK_OUT_W] = {1'b0, ch[i]} - {1'b0, cfg_i.center};
    end
  end

  assign online_dec = (online_q != '0) ? online_q - WDOG_W'(1) : online_q;
  assign expire     = (online_dec == '0);

  // The result slot doubles as the state; it can be rewritten once it is empty or taken.
  assign take_o   = !out_v_q || out_o.ready;
  assign advance  = item_i.valid && take_o;
  assign do_frame = advance && !item_i.tick && item_i.frame_done && frame_ok;
  assign do_clear = advance && item_i.tick && expire;
  assign do_keys  = do_frame || do_clear;
  assign key_in   = do_frame ? keys_now : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      cause_q   <= CAUSE_FRAME;
      lost_q    <= 1'b0;
      online_q  <= '0;
      stick_q   <= '0;
      sw_q      <= '0;
      mouse_q   <= '0;
      pressed_q <= '0;
      rise_q    <= '0;
      fall_q    <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        hold_q[k] <= '0;
      end
    end else begin
      if (take_o) begin
        out_v_q <= do_keys;
      end
      if (advance && item_i.tick) begin
        online_q <= online_dec;
      end
      if (do_frame) begin
        cause_q  <= CAUSE_FRAME;
        lost_q   <= 1'b0;
        online_q <= cfg_i.reload;
        stick_q  <= stick_d;
        sw_q     <= {sw1, sw0};
        mouse_q  <= {frame_i[11], frame_i[10], frame_i[9],
                     frame_i[8], frame_i[7], frame_i[6]};
      end
      if (do_clear) begin
        cause_q <= CAUSE_WATCHDOG;
        lost_q  <= 1'b1;
        stick_q <= '0;
        sw_q    <= '0;
        mouse_q <= '0;
      end
      if (do_keys) begin
        pressed_q <= key_in;
        rise_q    <= key_in & ~pressed_q;
        fall_q    <= ~key_in & pressed_q;
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (!key_in[k]) begin
            hold_q[k] <= '0;
          end else if (!(&hold_q[k])) begin
            hold_q[k] <= hold_q[k] + HOLD_BITS'(1);
          end
        end
      end
    end
  end

  // Hold counts are shown saturated to one byte.
  always_comb begin
    hold_ext = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      hold_ext = {8'd0, hold_q[k]};
      hold8[k] = (hold_ext > (HOLD_BITS+8)'(255)) ? 8'hFF : hold_ext[7:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      out_o.hold_low[i*8 +: 8]  = hold8[i];
      out_o.hold_mid[i*8 +: 8]  = hold8[i + 6];
      out_o.hold_high[i*8 +: 8] = hold8[i + 12];
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.cause         = cause_q;
  assign out_o.link_lost     = lost_q;
  assign out_o.sticks_packed = stick_q;
  assign out_o.switch_pair   = sw_q;
  assign out_o.mouse_packed  = mouse_q;
  assign out_o.keys_pressed  = pressed_q;
  assign out_o.keys_rising   = rise_q;
  assign out_o.keys_falling  = fall_q;

endmodule

// File: design/rc_receiver_frame_decoder.sv
// Top level of the receiver frame decoder: configuration registers and the two stages.
// Takes one beat per clock, either a received byte or a 10 ms tick, and emits a result for
// each accepted 18-byte frame that passes its checks and for each tick that leaves the link
// watchdog at zero. An accepted beat is registered in the input stage and then processed by a
// single decode-and-update stage whose state registers form the result register; the held
// beat is processed only when the result slot is empty or being taken. Sustained throughput
// is one beat per cycle; the input stalls only while a finished result waits on the output
// and the input stage holds a beat. Configuration writes take effect at the next edge.
module rc_receiver_frame_decoder import rcfd_pkg::*; #(
  parameter int HOLD_BITS = HOLD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  rcfd_in_if.sink               in_i,
  rcfd_out_if.source            out_o
);

  cfg_t       cfg_q;
  item_t      item;
  logic [7:0] frame [FRAME_BYTES];
  logic       take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stick_min <= STICK_MIN_RST;
      cfg_q.stick_max <= STICK_MAX_RST;
      cfg_q.center    <= CENTER_RST;
      cfg_q.reload    <= WDOG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STICK_MIN: cfg_q.stick_min <= cfg_wdata_i[STICK_W-1:0];
        CFG_STICK_MAX: cfg_q.stick_max <= cfg_wdata_i[STICK_W-1:0];
        CFG_CENTER:    cfg_q.center    <= cfg_wdata_i[STICK_W-1:0];
        CFG_WDOG:      cfg_q.reload    <= cfg_wdata_i[WDOG_W-1:0];
        default: ;
      endcase
    end
  end

  rcfd_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .op_i        (in_i.op),
    .rx_byte_i   (in_i.rx_byte),
    .frame_end_i (in_i.frame_end),
    .take_i      (take),
    .item_o      (item),
    .frame_o     (frame)
  );

  rcfd_decode #(
    .HOLD_BITS (HOLD_BITS)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .item_i  (item),
    .frame_i (frame),
    .take_o  (take),
    .out_o   (out_o)
  );

endmodule
